// ===== hdl/hbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbd_pkg: shared types and constants of the Huffman bit-serial decoder
// Beat payloads, table entry layout, result status codes and sequencer states.
// ----------------------------------------------------------------------------
package hbd_pkg;

    localparam int CODE_W  = 32;
    localparam int LEN_W   = 6;
    localparam int SLOT_W  = 8;
    localparam int COUNT_W = 9;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_BIT  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMATCH = 2'd1;
    localparam logic [1:0] ST_OVERRUN = 2'd2;

    typedef struct packed {
        logic              cmd;
        logic [SLOT_W-1:0] entry_index;
        logic [LEN_W-1:0]  entry_length;
        logic [CODE_W-1:0] entry_code;
        logic              bit_value;
        logic              stream_last;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_W-1:0] symbol_index;
        logic [1:0]        status;
    } t_out_item;

    typedef struct packed {
        logic [LEN_W-1:0]  length;
        logic [CODE_W-1:0] code;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

// ===== hdl/hbd_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbd_table: code table memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hbd_table #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  hbd_pkg::t_entry  i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output hbd_pkg::t_entry  o_rd_data
);

    hbd_pkg::t_entry r_mem [DEPTH];
    hbd_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/huffman_bit_serial_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_bit_serial_decoder: bit-serial Huffman decoder with table search
// Shifts stream bits into a code accumulator and searches a code table.
// ----------------------------------------------------------------------------
// A load beat writes one (length, code) entry into the table.
// A bit beat shifts the bit into the accumulator, then a sequencer walks the
// table memory one entry per cycle through a single compare unit, in index
// order from slot 0, stopping at the first entry whose length equals the bits
// taken and whose code equals the accumulator. A bit beat therefore occupies
// the block for a walk of up to entry_count slots, with entry_count clamped to
// the table depth (fewer when a match ends the walk early; a bit that gives no
// result skips the output step, and a full output register that is stalled
// holds the block longer); the single read port of the table memory sets this pace.
// Results leave through an output register, so the next beat is taken while
// a result still waits downstream. Table entries are undefined until loaded;
// keep entry_count within the loaded slots. Write entry_count only while the
// block is idle.
// ----------------------------------------------------------------------------
module huffman_bit_serial_decoder #(
    parameter int MAX_ENTRIES  = 256,
    parameter int MAX_CODE_LEN = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input beats
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  hbd_pkg::t_in_item                 i_in_item,
    // result beats
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output hbd_pkg::t_out_item                o_out_item,
    // entry_count register write
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [hbd_pkg::COUNT_W-1:0]       i_cfg_data
);

    // Table address width and a counter width that can also hold the depth.
    localparam int AW    = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    hbd_pkg::t_state r_state, n_state;

    // Search limit, clamped to the table depth when written.
    logic [CNT_W-1:0] r_limit;

    // Code accumulator and bit count.
    logic [hbd_pkg::CODE_W-1:0] r_acc, n_acc;
    logic [hbd_pkg::LEN_W-1:0]  r_bits, n_bits;
    logic                       r_last, n_last;

    // Scan pointers: r_addr is the next slot to read, r_chk_idx the slot whose
    // data sits on the memory output when r_chk_valid is high.
    logic [CNT_W-1:0] r_addr, n_addr;
    logic [CNT_W-1:0] r_chk_idx, n_chk_idx;
    logic             r_chk_valid, n_chk_valid;

    // Pending result and output register.
    hbd_pkg::t_out_item r_res, n_res;
    hbd_pkg::t_out_item r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic             in_accept;
    logic             wr_en;
    hbd_pkg::t_entry  wr_data;
    logic             rd_en;
    hbd_pkg::t_entry  rd_data;
    logic             hit;
    logic             scan_end;
    logic             at_limit;
    logic             out_free;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != hbd_pkg::S_IDLE);
    assign o_cfg_ready = (r_state == hbd_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign out_free    = !r_out_valid || !i_out_stall;

    // Drop loads aimed beyond the table.
    assign wr_en = in_accept && (i_in_item.cmd == hbd_pkg::CMD_LOAD)
                   && (32'(i_in_item.entry_index) < MAX_ENTRIES);
    assign wr_data.length = i_in_item.entry_length;
    assign wr_data.code   = i_in_item.entry_code;

    hbd_table #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (AW'(i_in_item.entry_index)),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr[AW-1:0]),
        .o_rd_data (rd_data)
    );

    // Shared compare unit: one entry per cycle against the accumulator.
    assign hit = r_chk_valid && (rd_data.length == r_bits) && (rd_data.code == r_acc);

    // The walk ends on a hit, after the last slot is checked, or at once for
    // an empty table.
    assign scan_end = hit || (r_limit == '0)
                      || (r_chk_valid && ((r_chk_idx + CNT_W'(1)) == r_limit));

    assign at_limit = (r_bits >= hbd_pkg::LEN_W'(MAX_CODE_LEN));

    assign rd_en = (r_state == hbd_pkg::S_SCAN) && (r_addr != r_limit) && !scan_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hbd_pkg::S_IDLE;
            r_limit     <= '0;
            r_acc       <= '0;
            r_bits      <= '0;
            r_last      <= 1'b0;
            r_addr      <= '0;
            r_chk_idx   <= '0;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_bits      <= n_bits;
            r_last      <= n_last;
            r_addr      <= n_addr;
            r_chk_idx   <= n_chk_idx;
            r_chk_valid <= n_chk_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                if (32'(i_cfg_data) > MAX_ENTRIES) begin
                    r_limit <= CNT_W'(MAX_ENTRIES);
                end else begin
                    r_limit <= CNT_W'(i_cfg_data);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_out <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_bits      = r_bits;
        n_last      = r_last;
        n_addr      = r_addr;
        n_chk_idx   = r_chk_idx;
        n_chk_valid = 1'b0;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        case (r_state)
            hbd_pkg::S_IDLE: begin
                // Shift the bit in and start the walk at slot 0.
                if (in_accept && (i_in_item.cmd == hbd_pkg::CMD_BIT)) begin
                    n_acc   = {r_acc[hbd_pkg::CODE_W-2:0], i_in_item.bit_value};
                    n_bits  = r_bits + hbd_pkg::LEN_W'(1);
                    n_last  = i_in_item.stream_last;
                    n_addr  = '0;
                    n_state = hbd_pkg::S_SCAN;
                end
            end

            hbd_pkg::S_SCAN: begin
                n_chk_valid = rd_en;
                n_chk_idx   = r_addr;
                if (rd_en) begin
                    n_addr = r_addr + CNT_W'(1);
                end
                if (scan_end) begin
                    if (hit) begin
                        n_res.symbol_index = 8'(r_chk_idx);
                        n_res.status       = hbd_pkg::ST_OK;
                    end else if (r_last) begin
                        n_res.symbol_index = '0;
                        n_res.status       = hbd_pkg::ST_OVERRUN;
                    end else begin
                        n_res.symbol_index = '0;
                        n_res.status       = hbd_pkg::ST_NOMATCH;
                    end
                    // Any result or end of stream resynchronizes the decoder.
                    if (hit || r_last || at_limit) begin
                        n_acc   = '0;
                        n_bits  = '0;
                        n_state = hbd_pkg::S_DONE;
                    end else begin
                        n_state = hbd_pkg::S_IDLE;
                    end
                end
            end

            hbd_pkg::S_DONE: begin
                // Hold the result until the output register frees up.
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = hbd_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = hbd_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== bench/huffman_bit_serial_decoder_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_bit_serial_decoder_check: result checker for the Huffman decoder
// Watches the input, result and register channels, predicts every result
// beat from its own copy of the code table, and compares field by field.
// ----------------------------------------------------------------------------
module huffman_bit_serial_decoder_check #(
    parameter int MAX_ENTRIES  = 256,
    parameter int MAX_CODE_LEN = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  hbd_pkg::t_in_item           i_in_item,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  hbd_pkg::t_out_item          i_out_item,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [hbd_pkg::COUNT_W-1:0] i_cfg_data,
    output int                          o_pending,
    output int                          o_mismatches
);

    localparam int REPORT_LIMIT = 10;

    logic [hbd_pkg::CODE_W-1:0]  model_code [MAX_ENTRIES];
    logic [hbd_pkg::LEN_W-1:0]   model_len  [MAX_ENTRIES];
    logic [hbd_pkg::CODE_W-1:0]  shift_code;
    logic [hbd_pkg::LEN_W-1:0]   shift_count;
    logic [hbd_pkg::COUNT_W-1:0] search_count;
    hbd_pkg::t_out_item          expected_symbols [$];
    int                          mismatches = 0;

    // Apply one input beat to the shadow decoder; queue the result it causes.
    task automatic decode_beat(input hbd_pkg::t_in_item beat);
        int                 span;
        int                 s;
        logic               found;
        hbd_pkg::t_out_item res;
        begin
            if (beat.cmd == hbd_pkg::CMD_LOAD) begin
                if (int'(beat.entry_index) < MAX_ENTRIES) begin
                    model_len[beat.entry_index]  = beat.entry_length;
                    model_code[beat.entry_index] = beat.entry_code;
                end
            end else begin
                shift_code  = {shift_code[hbd_pkg::CODE_W-2:0], beat.bit_value};
                shift_count = shift_count + hbd_pkg::LEN_W'(1);
                span  = (search_count > MAX_ENTRIES) ? MAX_ENTRIES : int'(search_count);
                found = 1'b0;
                res   = '0;
                for (s = 0; s < span && !found; s++) begin
                    if (model_len[s] == shift_count && model_len[s] <= MAX_CODE_LEN &&
                        model_code[s] == shift_code) begin
                        found            = 1'b1;
                        res.symbol_index = s[hbd_pkg::SLOT_W-1:0];
                        res.status       = hbd_pkg::ST_OK;
                    end
                end
                if (!found && beat.stream_last) begin
                    found      = 1'b1;
                    res.status = hbd_pkg::ST_OVERRUN;
                end else if (!found && shift_count >= MAX_CODE_LEN) begin
                    found      = 1'b1;
                    res.status = hbd_pkg::ST_NOMATCH;
                end
                // Any result, and any last bit, starts the next code clean.
                if (found || beat.stream_last) begin
                    shift_code  = '0;
                    shift_count = '0;
                end
                if (found)
                    expected_symbols.push_back(res);
            end
        end
    endtask

    always @(posedge i_clk) begin
        hbd_pkg::t_out_item want;
        if (!i_rst_n) begin
            shift_code   = '0;
            shift_count  = '0;
            search_count = '0;
            expected_symbols.delete();
        end else begin
            // Compare first: a result at this edge never stems from this edge's input.
            if (i_out_valid && !i_out_stall) begin
                if (expected_symbols.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: result beat with nothing expected: symbol %0d status %0d",
                                 $realtime, i_out_item.symbol_index, i_out_item.status);
                end else begin
                    want = expected_symbols.pop_front();
                    if (i_out_item.symbol_index !== want.symbol_index ||
                        i_out_item.status !== want.status) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"%0t: result mismatch: expected symbol %0d status %0d,",
                                      " got symbol %0d status %0d"},
                                     $realtime, want.symbol_index, want.status,
                                     i_out_item.symbol_index, i_out_item.status);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                search_count = i_cfg_data;
            if (i_in_valid && !i_in_stall)
                decode_beat(i_in_item);
        end
        o_pending    <= expected_symbols.size();
        o_mismatches <= mismatches;
    end

endmodule

// ===== bench/huffman_bit_serial_decoder_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_bit_serial_decoder_test: stimulus and verdict for the Huffman decoder
// Loads code tables, streams code bits under several entry counts and idle
// patterns, and leaves prediction and comparison to the checker beside it.
// ----------------------------------------------------------------------------
module huffman_bit_serial_decoder_test;

    localparam int ENTRY_SLOTS  = 256;
    localparam int CODE_LIMIT   = 32;
    // A bit beat may walk the whole table: a full walk of every slot, plus margin.
    localparam int DRAIN_CYCLES = ENTRY_SLOTS + 16;
    localparam int HOLD_CYCLES  = 600;

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        in_valid    = 1'b0;
    hbd_pkg::t_in_item           in_item     = '0;
    logic                        out_stall   = 1'b0;
    logic                        cfg_valid   = 1'b0;
    logic [hbd_pkg::COUNT_W-1:0] cfg_data    = '0;
    logic                        o_in_stall;
    logic                        o_out_valid;
    hbd_pkg::t_out_item          o_out_item;
    logic                        o_cfg_ready;
    int                          pending;
    int                          mismatches;

    // Stimulus side bookkeeping: a copy of what was loaded, to build real codes.
    logic [hbd_pkg::LEN_W-1:0]   shadow_len  [ENTRY_SLOTS];
    logic [hbd_pkg::CODE_W-1:0]  shadow_code [ENTRY_SLOTS];
    int                          span          = 0;
    int unsigned                 beats_sent    = 0;
    int unsigned                 send_idle_pct = 0;
    int unsigned                 recv_idle_pct = 0;

    // Long receiver hold-off, requested once by the stimulus.
    logic                        hold_req      = 1'b0;
    logic                        hold_served   = 1'b0;
    int unsigned                 hold_left     = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    huffman_bit_serial_decoder #(
        .MAX_ENTRIES  (ENTRY_SLOTS),
        .MAX_CODE_LEN (CODE_LIMIT)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    huffman_bit_serial_decoder_check #(
        .MAX_ENTRIES  (ENTRY_SLOTS),
        .MAX_CODE_LEN (CODE_LIMIT)
    ) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (o_out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    // Receiver: stall at the current idle rate; once asked, hold off for a
    // long fixed stretch so the block backs up and stalls its own input.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_served) begin
            out_stall   <= 1'b1;
            hold_left   <= HOLD_CYCLES - 1;
            hold_served <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Offer one beat and hold it until accepted. Idle gaps drop valid first;
    // a back-to-back beat keeps valid high with a single assignment.
    task automatic send_beat(input hbd_pkg::t_in_item beat);
        begin
            while ($urandom_range(99) < send_idle_pct) begin
                in_valid <= 1'b0;
                @(posedge i_clk);
            end
            in_valid <= 1'b1;
            in_item  <= beat;
            @(posedge i_clk);
            while (o_in_stall)
                @(posedge i_clk);
            beats_sent++;
        end
    endtask

    // Stream bit; fields a bit beat does not use carry random junk.
    task automatic send_bit(input logic value, input logic last);
        hbd_pkg::t_in_item beat;
        begin
            beat.cmd          = hbd_pkg::CMD_BIT;
            beat.entry_index  = hbd_pkg::SLOT_W'($urandom);
            beat.entry_length = hbd_pkg::LEN_W'($urandom);
            beat.entry_code   = $urandom;
            beat.bit_value    = value;
            beat.stream_last  = last;
            send_beat(beat);
        end
    endtask

    task automatic send_load(input int slot, input logic [hbd_pkg::LEN_W-1:0] len,
                             input logic [hbd_pkg::CODE_W-1:0] code);
        hbd_pkg::t_in_item beat;
        begin
            beat.cmd          = hbd_pkg::CMD_LOAD;
            beat.entry_index  = slot[hbd_pkg::SLOT_W-1:0];
            beat.entry_length = len;
            beat.entry_code   = code;
            beat.bit_value    = 1'($urandom);
            beat.stream_last  = 1'($urandom);
            shadow_len[slot]  = len;
            shadow_code[slot] = code;
            send_beat(beat);
        end
    endtask

    // Mostly short right-aligned codes so small tables decode often; a few
    // long, full-width, zero-length, over-limit and too-wide entries.
    task automatic load_random_entry(input int slot);
        int unsigned                pick;
        logic [hbd_pkg::LEN_W-1:0]  len;
        logic [hbd_pkg::CODE_W-1:0] code;
        begin
            pick = $urandom_range(99);
            code = $urandom;
            if (pick < 60)      len = hbd_pkg::LEN_W'($urandom_range(6, 1));
            else if (pick < 75) len = hbd_pkg::LEN_W'($urandom_range(16, 7));
            else if (pick < 85) len = hbd_pkg::LEN_W'($urandom_range(31, 17));
            else if (pick < 91) len = hbd_pkg::LEN_W'(CODE_LIMIT);
            else if (pick < 95) len = '0;
            else                len = hbd_pkg::LEN_W'($urandom_range(63, 33));
            // Trim to the length most of the time; otherwise leave stray high bits.
            if (len != 0 && len < CODE_LIMIT && $urandom_range(99) < 88)
                code = code & hbd_pkg::CODE_W'((64'd1 << len) - 64'd1);
            send_load(slot, len, code);
        end
    endtask

    // Drop valid and wait until every result is out and the last search is done.
    task automatic wait_drained();
        begin
            in_valid <= 1'b0;
            @(posedge i_clk);
            while (pending != 0)
                @(posedge i_clk);
            repeat (DRAIN_CYCLES) @(posedge i_clk);
        end
    endtask

    task automatic write_entry_count(input logic [hbd_pkg::COUNT_W-1:0] value);
        begin
            wait_drained();
            cfg_valid <= 1'b1;
            cfg_data  <= value;
            @(posedge i_clk);
            while (!o_cfg_ready)
                @(posedge i_clk);
            cfg_valid <= 1'b0;
            span = (value > ENTRY_SLOTS) ? ENTRY_SLOTS : int'(value);
        end
    endtask

    // Random stream: mostly whole codes of searched entries, some cut short
    // by a last bit, some 32-bit runs of noise, loose bits and table rewrites.
    task automatic run_stream(input int unsigned count);
        int unsigned                stop;
        int unsigned                pick;
        int                         slot;
        int                         cut;
        int                         k;
        logic                       last;
        logic [hbd_pkg::LEN_W-1:0]  len;
        logic [hbd_pkg::CODE_W-1:0] code;
        begin
            stop = beats_sent + count;
            while (beats_sent < stop) begin
                pick = $urandom_range(99);
                slot = (span == 0) ? 0 : int'($urandom_range(span - 1));
                len  = shadow_len[slot];
                code = shadow_code[slot];
                if (pick < 75) begin
                    if (span != 0 && len != 0 && len <= CODE_LIMIT &&
                        (len == CODE_LIMIT || (code >> len) == 0)) begin
                        cut = (pick < 65) ? int'(len) : int'($urandom_range(len, 1));
                        for (k = 0; k < cut; k++) begin
                            last = (k == cut - 1) && (pick >= 65 || $urandom_range(9) == 0);
                            send_bit(code[len - 1 - k], last);
                        end
                    end else begin
                        send_bit(1'($urandom_range(1)), $urandom_range(9) == 0);
                    end
                end else if (pick < 83) begin
                    // Long enough to hit the code length limit; a last bit on
                    // the final one must win over no-match.
                    for (k = 0; k < CODE_LIMIT; k++)
                        send_bit(1'($urandom_range(1)),
                                 (k == CODE_LIMIT - 1) && ($urandom_range(1) != 0));
                end else if (pick < 94) begin
                    send_bit(1'($urandom_range(1)), $urandom_range(9) == 0);
                end else begin
                    load_random_entry(int'($urandom_range(ENTRY_SLOTS - 1)));
                end
            end
        end
    endtask

    initial begin
        int s;
        // Hold reset, then release it once for good.
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty search range: a bit can only end in an overrun. A load in
        // the middle of a code must leave the partial code alone.
        send_bit(1'b1, 1'b0);
        send_load(0, 6'd2, 32'h2);
        send_bit(1'b0, 1'b1);

        // Small hand-made table: dead entries (zero length, stray high bits,
        // over the length limit) next to both 32-bit extremes.
        send_load(1, 6'd0, 32'h0);
        send_load(2, 6'd3, 32'h8);
        send_load(3, 6'd32, 32'hFFFF_FFFF);
        send_load(4, 6'd32, 32'h0);
        send_load(5, 6'd40, 32'h0);
        send_load(6, 6'd3, 32'h6);
        write_entry_count(9'd7);
        send_bit(1'b1, 1'b0);
        send_bit(1'b0, 1'b0);
        // Match on the last bit still decodes as a symbol.
        send_bit(1'b1, 1'b0);
        send_bit(1'b1, 1'b0);
        send_bit(1'b0, 1'b1);
        // Stream ends mid-code.
        send_bit(1'b0, 1'b0);
        send_bit(1'b1, 1'b1);
        send_bit(1'b1, 1'b1);

        // Fill every slot so any entry count stays inside loaded entries.
        for (s = 0; s < ENTRY_SLOTS; s++)
            load_random_entry(s);

        // Sender sparse, receiver mostly stalled.
        send_idle_pct = 30;
        recv_idle_pct <= 82;
        write_entry_count(9'd1);
        run_stream(120);
        write_entry_count(9'd4);
        run_stream(200);
        write_entry_count(9'd256);
        run_stream(40);

        // Swap: sender mostly idle, receiver stalls now and then.
        send_idle_pct = 82;
        recv_idle_pct <= 30;
        write_entry_count(9'd511);
        run_stream(40);
        write_entry_count(9'd16);
        run_stream(200);
        write_entry_count(9'd2);
        run_stream(150);

        // Full rate both ways, with one long receiver hold-off to back up the block.
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        write_entry_count(9'd8);
        hold_req <= 1'b1;
        run_stream(150);
        write_entry_count(9'd64);
        run_stream(150);
        write_entry_count(9'd3);
        run_stream(150);
        write_entry_count(9'd0);
        run_stream(60);

        wait_drained();
        if (mismatches == 0 && pending == 0) begin
            $display("PASS huffman_bit_serial_decoder");
        end else begin
            $display("FAIL huffman_bit_serial_decoder");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("FAIL huffman_bit_serial_decoder");
        $finish;
    end

endmodule
